### sv/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants of the tick process scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int MAX_ENTRIES_DEF = 128;
  // A load index is 7 bits wide, so no entry at or above this is ever loaded.
  localparam int TBL_LIMIT       = 128;

  localparam int IDX_W      = 7;
  localparam int BURST_W    = 16;
  localparam int PRIO_W     = 4;
  localparam int ARR_W      = 16;
  localparam int TIME_W     = 32;
  localparam int Q_W        = 16;
  localparam int PC_W       = 8;
  localparam int POL_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [Q_W-1:0]  QUANTUM_RESET = 16'd100;
  localparam logic [PC_W-1:0] COUNT_RESET   = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd2;

  localparam logic [POL_W-1:0] POL_RR   = 2'd0;
  localparam logic [POL_W-1:0] POL_PRIO = 2'd1;
  localparam logic [POL_W-1:0] POL_SJF  = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [PRIO_W-1:0]  prio_lvl;
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] burst;
  } entry_t;

endpackage

### sv/tps_ram.sv
// ----------------------------------------------------------------------------
// tps_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/tick_process_scheduler.sv
// ----------------------------------------------------------------------------
// tick_process_scheduler
// Time-slice scheduler over a process table held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per command. in_tuser = cmd (0 load entry, 1 tick).
//           A load writes burst, priority and arrival of one entry, clears
//           its done flag and restarts the clock and the round-robin pointer.
//   out_* : one word per command: picked entry, idle flag, completion flags
//           and the clock after the command.
//   cfg_* : register writes (0 policy, 1 quantum, 2 entries in use), taken
//           always; user must write only while no command is in flight.
// Timing: every command scans the n entries in use, one RAM read per cycle,
//   then the last read returns, the scan closes and the write-back stage
//   loads the result word; the next command is taken when the scanner
//   returns to idle after the write-back, not while the scan runs.
//   One command is in flight at a time; in_tready is high when the scanner
//   is free, also while the previous result still waits in the output
//   register. A stalled receiver holds the scanner at write-back.
// Reset: config returns to round robin, quantum 100, one entry; all done
//   flags are set and the clock and pointer are zero. Table contents are
//   not cleared, so no command is blocked after reset.
// ----------------------------------------------------------------------------
module tick_process_scheduler #(
  parameter int MAX_ENTRIES = tps_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: entry_index[6:0], burst_length[22:7], priority_level[26:23],
  //           arrival_time[42:27], zero fill [47:43]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tps_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: cmd[0]
  input  logic [0:0]                       in_tuser,
  // out_tdata: selected_index[6:0], finished_now[7], all_done[8],
  //            current_time[40:9], zero fill [47:41]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tuser: idle[0]
  output logic [0:0]                       out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import tps_pkg::*;

  localparam int AW     = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int TBL_N  = (MAX_ENTRIES < TBL_LIMIT) ? MAX_ENTRIES : TBL_LIMIT;
  localparam int TW     = $clog2(TBL_N);
  localparam int EW     = $bits(entry_t);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]          state_r;
  logic [POL_W-1:0]    policy_r;
  logic [Q_W-1:0]      quantum_r;
  logic [PC_W-1:0]     count_r;
  logic [TIME_W-1:0]   clock_r;
  logic [AW-1:0]       ptr_r;
  logic [TBL_N-1:0]    done_r;

  logic                is_tick_r;
  logic [AW-1:0]       scan_idx_r;
  logic [CNT_W-1:0]    issue_cnt_r;
  logic                pend_vld_r;
  logic [AW-1:0]       pend_idx_r;
  logic                best_vld_r;
  logic [AW-1:0]       best_idx_r;
  entry_t              best_r;
  logic [1:0]          nd_cnt_r;

  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                out_idle_r;

  logic [CNT_W-1:0]    n_use;
  logic                is_prio, is_sjf, is_rr;
  logic                in_acc, load_wr, idx_ok;
  logic [IDX_W-1:0]    in_idx;
  entry_t              in_entry;
  logic [AW-1:0]       rr_start;
  logic                issue;
  logic [CNT_W-1:0]    idx_inc;
  logic [AW-1:0]       idx_next;
  logic                pend_in_tbl, done_pend, elig;
  entry_t              rd_entry;
  logic                take;
  logic                fire_out;
  logic [BURST_W-1:0]  rem_new;
  logic                ran, fin;
  logic [TIME_W:0]     clk_sum;
  logic [TIME_W-1:0]   clk_sat;
  logic [CNT_W-1:0]    sel_inc;
  logic                all_done;
  logic                ram_we, ram_re;
  logic [TW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  logic [EW-1:0]       ram_rdata;

  // entries in use, clamped to [1, MAX_ENTRIES]
  always_comb begin
    if (count_r == '0) begin
      n_use = CNT_W'(1);
    end else if (32'(count_r) > 32'(MAX_ENTRIES)) begin
      n_use = CNT_W'(MAX_ENTRIES);
    end else begin
      n_use = CNT_W'(count_r);
    end
  end

  assign is_prio = (policy_r == POL_PRIO);
  assign is_sjf  = (policy_r == POL_SJF);
  assign is_rr   = !is_prio && !is_sjf;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign in_idx             = in_tdata[6:0];
  assign in_entry.burst     = in_tdata[22:7];
  assign in_entry.remaining = in_tdata[22:7];
  assign in_entry.prio_lvl  = in_tdata[26:23];
  assign in_entry.arrival   = in_tdata[42:27];
  assign idx_ok  = (32'(in_idx) < 32'(MAX_ENTRIES)) && (32'(in_idx) < 32'(TBL_N));
  assign load_wr = in_acc && (in_tuser[0] == CMD_LOAD) && idx_ok;

  assign rr_start = (CNT_W'(ptr_r) < n_use) ? ptr_r : '0;

  // scan: address issue
  assign issue    = (state_r == ST_SCAN) && (issue_cnt_r < n_use);
  assign idx_inc  = CNT_W'(scan_idx_r) + CNT_W'(1);
  assign idx_next = (idx_inc == n_use) ? '0 : AW'(idx_inc);

  // scan: data stage
  assign rd_entry    = entry_t'(ram_rdata);
  assign pend_in_tbl = (32'(pend_idx_r) < 32'(TBL_N));
  assign done_pend   = pend_in_tbl ? done_r[TW'(pend_idx_r)] : 1'b1;
  assign elig        = !done_pend && ({16'b0, rd_entry.arrival} <= clock_r);

  always_comb begin
    take = 1'b0;
    if (pend_vld_r && elig) begin
      if (!best_vld_r) begin
        take = 1'b1;
      end else if (is_prio) begin
        take = (rd_entry.prio_lvl < best_r.prio_lvl);
      end else if (is_sjf) begin
        take = (rd_entry.burst < best_r.burst);
      end
    end
  end

  // write-back
  assign fire_out = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign rem_new  = (best_r.remaining > quantum_r) ? best_r.remaining - quantum_r : '0;
  assign ran      = is_tick_r && best_vld_r;
  assign fin      = ran && (rem_new == '0);
  assign clk_sum  = {1'b0, clock_r} + (TIME_W+1)'(quantum_r);
  assign clk_sat  = clk_sum[TIME_W] ? '1 : clk_sum[TIME_W-1:0];
  assign sel_inc  = CNT_W'(best_idx_r) + CNT_W'(1);
  assign all_done = (nd_cnt_r == 2'd0) || ((nd_cnt_r == 2'd1) && fin);

  always_comb begin
    ram_we    = load_wr || (fire_out && ran);
    ram_waddr = load_wr ? TW'(in_idx) : TW'(best_idx_r);
    ram_wdata = in_entry;
    if (!load_wr) begin
      ram_wdata           = best_r;
      ram_wdata.remaining = rem_new;
    end
  end

  assign ram_re = issue && (32'(scan_idx_r) < 32'(TBL_N));

  tps_ram #(
    .WIDTH (EW),
    .DEPTH (TBL_N)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (TW'(scan_idx_r)),
    .rdata (ram_rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= POL_RR;
      quantum_r <= QUANTUM_RESET;
      count_r   <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POLICY:  policy_r  <= cfg_data[POL_W-1:0];
        CFG_QUANTUM: quantum_r <= cfg_data[Q_W-1:0];
        CFG_COUNT:   count_r   <= cfg_data[PC_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clock_r     <= '0;
      ptr_r       <= '0;
      done_r      <= '1;
      pend_vld_r  <= 1'b0;
      best_vld_r  <= 1'b0;
      nd_cnt_r    <= 2'd0;
      is_tick_r   <= 1'b0;
      issue_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_wr) begin
        done_r[TW'(in_idx)] <= 1'b0;
        clock_r             <= '0;
        ptr_r               <= '0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r     <= ST_SCAN;
            is_tick_r   <= (in_tuser[0] == CMD_TICK);
            issue_cnt_r <= '0;
            best_vld_r  <= 1'b0;
            nd_cnt_r    <= 2'd0;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            issue_cnt_r <= issue_cnt_r + CNT_W'(1);
          end
          if (take) begin
            best_vld_r <= 1'b1;
          end
          if (pend_vld_r && !done_pend && (nd_cnt_r != 2'd2)) begin
            nd_cnt_r <= nd_cnt_r + 2'd1;
          end
          if (!issue && !pend_vld_r) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fire_out) begin
            state_r <= ST_IDLE;
            if (is_tick_r) begin
              clock_r <= clk_sat;
            end
            if (fin) begin
              done_r[TW'(best_idx_r)] <= 1'b1;
            end
            if (ran && is_rr) begin
              ptr_r <= (sel_inc >= n_use) ? '0 : AW'(sel_inc);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      pend_vld_r <= issue;

      if (fire_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      scan_idx_r <= (in_tuser[0] == CMD_TICK && is_rr) ? rr_start : '0;
    end else if (issue) begin
      scan_idx_r <= idx_next;
    end
    pend_idx_r <= scan_idx_r;
    if (take) begin
      best_idx_r <= pend_idx_r;
      best_r     <= rd_entry;
    end
    if (fire_out) begin
      out_data_r <= {7'b0,
                     (is_tick_r ? clk_sat : clock_r),
                     all_done,
                     fin,
                     (ran ? IDX_W'(best_idx_r) : IDX_W'(0))};
      out_idle_r <= !ran;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_idle_r;

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (issue_cnt_r <= n_use))
    else $error("scan issued past the entries in use");

  a_nd_sat: assert property (@(posedge clk) disable iff (!rst_n)
    nd_cnt_r != 2'd3)
    else $error("pending count left its saturating range");

  a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) && fin |-> (best_vld_r && is_tick_r && !done_r[TW'(best_idx_r)]))
    else $error("completion on an entry that was not eligible");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> !in_tready || $past(!issue && !pend_vld_r) == 1'b0)
    else $error("input accepted while a scan was running");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fire_out && !ran |=> (out_tdata[6:0] == 7'd0) && out_tuser[0] && !out_tdata[7])
    else $error("idle result with a selected entry or completion");

endmodule
